>>> rtl/obk_pkg.sv
// Shared types, constants and codes for the depth-limited order book.
package obk_pkg;

	localparam int MAX_LEVELS = 16;
	localparam int PRICE_BITS = 32;
	localparam int QTY_BITS   = 32;
	localparam int CNT_BITS   = $clog2(MAX_LEVELS + 1);
	localparam int DEPTH_BITS = 5;
	localparam int ACT_BITS   = 3;

	typedef enum logic [ACT_BITS-1:0] {
		ACT_IGNORED  = 3'd0,
		ACT_DELETED  = 3'd1,
		ACT_UPDATED  = 3'd2,
		ACT_INSERTED = 3'd3,
		ACT_EVICTED  = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_DELETE,
		OP_UPDATE,
		OP_INSERT
	} cell_op_t;

	typedef struct packed {
		logic                  side;
		logic [PRICE_BITS-1:0] price;
		logic [QTY_BITS-1:0]   quantity;
	} req_t;

	typedef struct packed {
		action_t               action;
		logic [PRICE_BITS-1:0] evicted_price;
		logic [PRICE_BITS-1:0] best_price;
		logic [QTY_BITS-1:0]   best_quantity;
		logic [CNT_BITS-1:0]   level_count;
	} rsp_t;

	// request into one side's chain
	typedef struct packed {
		logic                  en;
		logic                  ask;
		logic [PRICE_BITS-1:0] price;
		logic [QTY_BITS-1:0]   qty;
	} chain_req_t;

	// broadcast to every cell of a chain
	typedef struct packed {
		cell_op_t              op;
		logic                  ask;
		logic [PRICE_BITS-1:0] price;
		logic [QTY_BITS-1:0]   qty;
	} cell_ctrl_t;

	// chain status back to the top level
	typedef struct packed {
		logic                  hit;
		logic                  at_end;
		logic [PRICE_BITS-1:0] last_price;
		logic [PRICE_BITS-1:0] head_price_nx;
		logic [QTY_BITS-1:0]   head_qty_nx;
	} chain_stat_t;

endpackage

>>> rtl/depth_limited_order_book.sv
// Top level of the depth-limited order book: bid and ask cell chains, counts, result register.
//
//   channel  | valid      | stall      | payload    | role
//   request  | req_valid  | req_stall  | req        | side, price, quantity in
//   result   | rsp_valid  | rsp_stall  | rsp        | action, evicted, best, count out
//   config   | cfg_we     | -          | cfg_wdata  | max_depth write
//
// For each request, all cells of the chosen side compare in parallel and
// shift in the same edge; the result is registered and shown the next cycle.
// One request per cycle while results are taken; a stalled result holds the request side.
// Reset clears both level counts and sets max_depth to 16; level storage needs no clearing.
module depth_limited_order_book (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  obk_pkg::req_t                    req,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output obk_pkg::rsp_t                    rsp,
	input  logic                             cfg_we,
	input  logic [obk_pkg::DEPTH_BITS-1:0]   cfg_wdata
);

	localparam int CB = obk_pkg::CNT_BITS;

	logic [obk_pkg::DEPTH_BITS-1:0] max_depth_q;
	logic [CB-1:0]                  bid_cnt_q;
	logic [CB-1:0]                  ask_cnt_q;
	logic                           rsp_valid_q;
	obk_pkg::rsp_t                  rsp_q;

	logic                           accept;
	obk_pkg::chain_req_t            bid_req;
	obk_pkg::chain_req_t            ask_req;
	obk_pkg::chain_stat_t           bid_stat;
	obk_pkg::chain_stat_t           ask_stat;
	obk_pkg::chain_stat_t           st;
	logic [CB-1:0]                  n;
	logic [CB-1:0]                  n_nx;
	logic [CB:0]                    depth;
	logic                           overflow;
	obk_pkg::rsp_t                  rsp_nx;

	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		bid_req.en    = accept && !req.side;
		bid_req.ask   = 1'b0;
		bid_req.price = req.price;
		bid_req.qty   = req.quantity;
		ask_req.en    = accept && req.side;
		ask_req.ask   = 1'b1;
		ask_req.price = req.price;
		ask_req.qty   = req.quantity;
	end

	obk_chain u_bid (
		.clk   (clk),
		.req   (bid_req),
		.count (bid_cnt_q),
		.stat  (bid_stat)
	);

	obk_chain u_ask (
		.clk   (clk),
		.req   (ask_req),
		.count (ask_cnt_q),
		.stat  (ask_stat)
	);

	always_comb begin
		st = req.side ? ask_stat : bid_stat;
		n  = req.side ? ask_cnt_q : bid_cnt_q;

		if (max_depth_q == '0)
			depth = (CB+1)'(1);
		else if ((CB+1)'(max_depth_q) > (CB+1)'(obk_pkg::MAX_LEVELS))
			depth = (CB+1)'(obk_pkg::MAX_LEVELS);
		else
			depth = (CB+1)'(max_depth_q);

		overflow = (n == CB'(obk_pkg::MAX_LEVELS)) || (({1'b0, n} + 1'b1) > depth);

		rsp_nx               = '0;
		rsp_nx.action        = obk_pkg::ACT_IGNORED;
		n_nx                 = n;
		if (st.hit) begin
			if (req.quantity == '0) begin
				rsp_nx.action = obk_pkg::ACT_DELETED;
				n_nx          = n - 1'b1;
			end else begin
				rsp_nx.action = obk_pkg::ACT_UPDATED;
			end
		end else if (req.quantity != '0) begin
			if (overflow) begin
				rsp_nx.action        = obk_pkg::ACT_EVICTED;
				rsp_nx.evicted_price = st.at_end ? req.price : st.last_price;
			end else begin
				rsp_nx.action = obk_pkg::ACT_INSERTED;
				n_nx          = n + 1'b1;
			end
		end
		rsp_nx.level_count = n_nx;
		if (n_nx != '0) begin
			rsp_nx.best_price    = st.head_price_nx;
			rsp_nx.best_quantity = st.head_qty_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_depth_q <= obk_pkg::DEPTH_BITS'(16);
			bid_cnt_q   <= '0;
			ask_cnt_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				max_depth_q <= cfg_wdata;
			if (accept) begin
				if (req.side)
					ask_cnt_q <= n_nx;
				else
					bid_cnt_q <= n_nx;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			rsp_q <= rsp_nx;
	end

endmodule

>>> rtl/obk_cell.sv
// One price level cell: holds a price and quantity, shifts with its neighbors.
module obk_cell (
	input  logic                          clk,
	input  obk_pkg::cell_ctrl_t           ctrl,
	input  logic                          occ,
	input  logic [obk_pkg::PRICE_BITS-1:0] left_pr,
	input  logic [obk_pkg::QTY_BITS-1:0]   left_qt,
	input  logic                          left_ge,
	input  logic                          mpre_in,
	input  logic [obk_pkg::PRICE_BITS-1:0] right_pr,
	input  logic [obk_pkg::QTY_BITS-1:0]   right_qt,
	output logic [obk_pkg::PRICE_BITS-1:0] pr,
	output logic [obk_pkg::QTY_BITS-1:0]   qt,
	output logic                          ge,
	output logic                          ahead,
	output logic                          mpre_out,
	output logic [obk_pkg::PRICE_BITS-1:0] pr_nx,
	output logic [obk_pkg::QTY_BITS-1:0]   qt_nx
);

	logic [obk_pkg::PRICE_BITS-1:0] pr_q;
	logic [obk_pkg::QTY_BITS-1:0]   qt_q;
	logic                          match;

	assign pr       = pr_q;
	assign qt       = qt_q;
	assign match    = occ && (pr_q == ctrl.price);
	assign ahead    = occ && (ctrl.ask ? (ctrl.price < pr_q) : (ctrl.price > pr_q));
	assign ge       = ahead || !occ;
	assign mpre_out = mpre_in || match;

	always_comb begin
		pr_nx = pr_q;
		qt_nx = qt_q;
		unique case (ctrl.op)
			obk_pkg::OP_DELETE: begin
				if (mpre_in || match) begin
					pr_nx = right_pr;
					qt_nx = right_qt;
				end
			end
			obk_pkg::OP_UPDATE: begin
				if (match)
					qt_nx = ctrl.qty;
			end
			obk_pkg::OP_INSERT: begin
				if (ge && !left_ge) begin
					pr_nx = ctrl.price;
					qt_nx = ctrl.qty;
				end else if (left_ge) begin
					pr_nx = left_pr;
					qt_nx = left_qt;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		pr_q <= pr_nx;
		qt_q <= qt_nx;
	end

endmodule

>>> rtl/obk_chain.sv
// One side of the book: a sorted row of level cells and its control.
module obk_chain (
	input  logic                        clk,
	input  obk_pkg::chain_req_t         req,
	input  logic [obk_pkg::CNT_BITS-1:0] count,
	output obk_pkg::chain_stat_t        stat
);

	localparam int N = obk_pkg::MAX_LEVELS;

	obk_pkg::cell_ctrl_t            ctrl;
	logic [obk_pkg::PRICE_BITS-1:0] pr    [N];
	logic [obk_pkg::QTY_BITS-1:0]   qt    [N];
	logic [obk_pkg::PRICE_BITS-1:0] pr_nx [N];
	logic [obk_pkg::QTY_BITS-1:0]   qt_nx [N];
	logic [N-1:0]                   occ;
	logic [N-1:0]                   ge;
	logic [N-1:0]                   ahead;
	logic [N-1:0]                   mpre;
	logic                           hit;

	assign hit = mpre[N-1];

	always_comb begin
		ctrl.ask   = req.ask;
		ctrl.price = req.price;
		ctrl.qty   = req.qty;
		if (!req.en)
			ctrl.op = obk_pkg::OP_NONE;
		else if (hit)
			ctrl.op = (req.qty == '0) ? obk_pkg::OP_DELETE : obk_pkg::OP_UPDATE;
		else if (req.qty != '0)
			ctrl.op = obk_pkg::OP_INSERT;
		else
			ctrl.op = obk_pkg::OP_NONE;
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		logic [obk_pkg::PRICE_BITS-1:0] l_pr;
		logic [obk_pkg::QTY_BITS-1:0]   l_qt;
		logic                          l_ge;
		logic                          l_mp;
		logic [obk_pkg::PRICE_BITS-1:0] r_pr;
		logic [obk_pkg::QTY_BITS-1:0]   r_qt;

		assign occ[i] = obk_pkg::CNT_BITS'(i) < count;

		if (i == 0) begin : g_first
			assign l_pr = '0;
			assign l_qt = '0;
			assign l_ge = 1'b0;
			assign l_mp = 1'b0;
		end else begin : g_mid
			assign l_pr = pr[i-1];
			assign l_qt = qt[i-1];
			assign l_ge = ge[i-1];
			assign l_mp = mpre[i-1];
		end

		if (i == N - 1) begin : g_last
			assign r_pr = '0;
			assign r_qt = '0;
		end else begin : g_inner
			assign r_pr = pr[i+1];
			assign r_qt = qt[i+1];
		end

		obk_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.occ      (occ[i]),
			.left_pr  (l_pr),
			.left_qt  (l_qt),
			.left_ge  (l_ge),
			.mpre_in  (l_mp),
			.right_pr (r_pr),
			.right_qt (r_qt),
			.pr       (pr[i]),
			.qt       (qt[i]),
			.ge       (ge[i]),
			.ahead    (ahead[i]),
			.mpre_out (mpre[i]),
			.pr_nx    (pr_nx[i]),
			.qt_nx    (qt_nx[i])
		);
	end

	always_comb begin
		stat.hit           = hit;
		stat.at_end        = (ahead == '0);
		stat.head_price_nx = pr_nx[0];
		stat.head_qty_nx   = qt_nx[0];
		stat.last_price    = '0;
		for (int i = 0; i < N; i++) begin
			if (count == obk_pkg::CNT_BITS'(i + 1))
				stat.last_price = stat.last_price | pr[i];
		end
	end

endmodule
